### rtl/pao_pkg.sv
package pao_pkg;

  localparam int PriceWidth   = 24;
  localparam int PriceFrac    = 8;
  localparam int RateFrac     = 16;
  localparam int OutWidth     = 32;
  localparam int LogFrac      = 24;
  localparam int LogSteps     = 24;
  localparam int MantWidth    = 31;
  localparam int CfgAddrWidth = 5;

  typedef enum logic [2:0] {
    RegRate   = 3'd0,
    RegVol    = 3'd1,
    RegStrike = 3'd2,
    RegCarry  = 3'd3,
    RegPut    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StNormal  = 2'd0,
    StPass    = 2'd1,
    StSat     = 2'd2,
    StInvalid = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    DsTabInit,
    DsTabRun,
    DsDivInit,
    DsDivRun,
    DsRootSq,
    DsRootRun,
    DsExpo,
    DsLogInit,
    DsLogRun,
    DsLogDone,
    DsReady
  } dstate_e;

  // Mantissas are Q1.30 values in [1, 2).
  typedef logic [MantWidth-1:0] mant_t;
  typedef mant_t [LogSteps:1] exp_tab_t;

  typedef struct packed {
    logic signed [31:0] expo;
    logic signed [31:0] ratio;
    logic signed [31:0] coef;
    logic               invalid;
    logic               unit;
    exp_tab_t           tab;
  } derived_t;

  typedef struct packed {
    logic                force_res;
    logic [OutWidth-1:0] fprice;
    status_e             fstatus;
    logic signed [7:0]   lexp;
    logic                sat;
    logic                under;
    logic signed [6:0]   ip;
  } side_t;

  typedef struct packed {
    mant_t m;
    logic  b;
  } log_step_t;

  // One fraction bit of log2: square the mantissa and renormalize.
  function automatic log_step_t log_step(mant_t m);
    logic [2*MantWidth-1:0] sq;
    logic [MantWidth:0]     t;
    log_step_t              r;
    sq = (2*MantWidth)'(m) * (2*MantWidth)'(m);
    t = sq[2*MantWidth-1:MantWidth-1];
    r.b = t[MantWidth];
    r.m = t[MantWidth] ? t[MantWidth:1] : t[MantWidth-1:0];
    return r;
  endfunction

  function automatic logic [4:0] msb_pos(logic [31:0] x);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic mant_t norm_mant(logic [31:0] x, logic [4:0] p);
    logic [31:0] s;
    s = x << (5'd31 - p);
    return s[31:1];
  endfunction

endpackage

### rtl/pao_derive.sv
module pao_derive (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              restart_i,
  input  logic [15:0]       rate_i,
  input  logic [15:0]       vol_i,
  input  logic [23:0]       strike_i,
  input  logic [16:0]       carry_i,
  input  logic              put_i,
  output logic              ready_o,
  output pao_pkg::derived_t derived_o
);
  import pao_pkg::*;

  localparam logic [5:0]  SqrtLast = 6'd30;
  localparam logic [5:0]  DivLast  = 6'd49;
  localparam logic [5:0]  LogLast  = 6'(LogSteps - 1);
  localparam logic [61:0] TabSeed  = 62'(1) << 61;
  localparam logic [28:0] QuotMax  = 29'(1) << 28;

  dstate_e state_q, state_d;
  logic [5:0]  cnt_q;
  logic [4:0]  idx_q;
  logic        dsel_q;
  logic [1:0]  lsel_q;

  logic [31:0] s2_q;
  logic [49:0] num_q;
  logic [31:0] drem_q;
  logic [61:0] rad_q;
  logic [32:0] srem_q;
  logic [30:0] root_q;
  logic [28:0] aq_q, cq_q;
  mant_t       lm_q;
  logic [23:0] lfr_q;
  logic [4:0]  lp_q;
  logic signed [31:0] lk_q, l1_q;
  exp_tab_t    tab_q;
  logic signed [31:0] expo_q, ratio_q, coef_q;
  logic        invalid_q, unit_q;

  // Shared square-root step (two radicand bits per cycle).
  logic [34:0] sq_rem2, sq_trial;
  logic [32:0] sq_rem_d;
  logic [30:0] sq_root_d;
  always_comb begin
    sq_rem2  = {srem_q, rad_q[61:60]};
    sq_trial = {2'b00, root_q, 2'b01};
    if (sq_rem2 >= sq_trial) begin
      sq_rem_d  = 33'(sq_rem2 - sq_trial);
      sq_root_d = {root_q[29:0], 1'b1};
    end else begin
      sq_rem_d  = 33'(sq_rem2);
      sq_root_d = {root_q[29:0], 1'b0};
    end
  end

  // Shared restoring divider step.
  logic [32:0] dv_rem2;
  logic [31:0] dv_rem_d;
  logic [49:0] dv_num_d;
  logic [28:0] dv_qsat;
  always_comb begin
    dv_rem2 = {drem_q, num_q[49]};
    if (dv_rem2 >= {1'b0, s2_q}) begin
      dv_rem_d = 32'(dv_rem2 - {1'b0, s2_q});
      dv_num_d = {num_q[48:0], 1'b1};
    end else begin
      dv_rem_d = dv_rem2[31:0];
      dv_num_d = {num_q[48:0], 1'b0};
    end
    dv_qsat = (dv_num_d > 50'(QuotMax)) ? QuotMax : dv_num_d[28:0];
  end

  logic [16:0] bmag;
  logic [49:0] num_a, num_c;
  assign bmag  = carry_i[16] ? 17'(-carry_i) : carry_i;
  assign num_a = 50'({bmag, 32'b0}) + 50'(s2_q >> 1);
  assign num_c = 50'({rate_i, 33'b0}) + 50'(s2_q >> 1);

  logic signed [30:0] a_w;
  logic signed [31:0] d_w;
  logic [28:0] dm_w;
  logic signed [33:0] y34;
  logic signed [31:0] y32;
  logic y_unit, y_bad;
  always_comb begin
    a_w = carry_i[16] ? -$signed({2'b00, aq_q}) : $signed({2'b00, aq_q});
    d_w = 32'(a_w) - 32'sd32768;
    dm_w = (d_w < 0) ? 29'(-d_w) : 29'(d_w);
    y34 = 34'sd32768 - 34'(a_w);
    if (put_i) y34 = y34 - $signed({3'b000, root_q});
    else       y34 = y34 + $signed({3'b000, root_q});
    y32 = 32'(y34);
    y_unit = (y32 == 32'sd65536);
    y_bad  = !y_unit && (put_i ? !(y32 < 0) : !(y32 > 32'sd65536));
  end

  logic signed [32:0] ydiff;
  logic [31:0] lx;
  logic [4:0]  lp_w;
  log_step_t   lst;
  logic signed [7:0]  lexp;
  logic signed [31:0] lval;
  always_comb begin
    ydiff = 33'(expo_q) - 33'sd65536;
    case (lsel_q)
      2'd0:    lx = 32'(strike_i);
      2'd1:    lx = (ydiff < 0) ? 32'(-ydiff) : 32'(ydiff);
      default: lx = (expo_q < 0) ? 32'(-expo_q) : 32'(expo_q);
    endcase
    lp_w = msb_pos(lx);
    lst  = log_step(lm_q);
    lexp = $signed({3'b000, lp_q}) - ((lsel_q == 2'd0) ? 8'sd8 : 8'sd16);
    lval = {lexp, lfr_q};
  end

  logic bad_cfg;
  assign bad_cfg = (vol_i == '0) || (strike_i == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      DsTabInit: state_d = DsTabRun;
      DsTabRun: begin
        if (cnt_q == SqrtLast) begin
          if (idx_q == 5'(LogSteps)) state_d = bad_cfg ? DsReady : DsDivInit;
          else state_d = DsTabInit;
        end
      end
      DsDivInit: state_d = DsDivRun;
      DsDivRun: begin
        if (cnt_q == DivLast) state_d = dsel_q ? DsRootSq : DsDivInit;
      end
      DsRootSq: state_d = DsRootRun;
      DsRootRun: begin
        if (cnt_q == SqrtLast) state_d = DsExpo;
      end
      DsExpo: state_d = (y_unit || y_bad) ? DsReady : DsLogInit;
      DsLogInit: state_d = DsLogRun;
      DsLogRun: begin
        if (cnt_q == LogLast) state_d = DsLogDone;
      end
      DsLogDone: state_d = (lsel_q == 2'd2) ? DsReady : DsLogInit;
      DsReady: state_d = DsReady;
      default: state_d = DsTabInit;
    endcase
    if (restart_i) state_d = DsTabInit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DsTabInit;
      idx_q   <= 5'd1;
      cnt_q   <= '0;
      dsel_q  <= 1'b0;
      lsel_q  <= '0;
    end else begin
      state_q <= state_d;
      if (restart_i) begin
        idx_q  <= 5'd1;
        cnt_q  <= '0;
        dsel_q <= 1'b0;
        lsel_q <= '0;
      end else begin
        case (state_q)
          DsTabInit, DsDivInit, DsRootSq, DsLogInit: cnt_q <= '0;
          DsTabRun: begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == SqrtLast) idx_q <= idx_q + 5'd1;
          end
          DsDivRun: begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == DivLast) dsel_q <= 1'b1;
          end
          DsRootRun, DsLogRun: cnt_q <= cnt_q + 6'd1;
          DsLogDone: lsel_q <= lsel_q + 2'd1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DsTabInit: begin
        rad_q  <= (idx_q == 5'd1) ? TabSeed : {1'b0, tab_q[idx_q - 5'd1], 30'b0};
        root_q <= '0;
        srem_q <= '0;
      end
      DsTabRun: begin
        rad_q  <= rad_q << 2;
        srem_q <= sq_rem_d;
        root_q <= sq_root_d;
        if (cnt_q == SqrtLast) begin
          tab_q[idx_q] <= sq_root_d;
          s2_q         <= 32'(vol_i) * 32'(vol_i);
          invalid_q    <= bad_cfg;
          unit_q       <= 1'b0;
          expo_q       <= '0;
        end
      end
      DsDivInit: begin
        num_q  <= dsel_q ? num_c : num_a;
        drem_q <= '0;
      end
      DsDivRun: begin
        num_q  <= dv_num_d;
        drem_q <= dv_rem_d;
        if (cnt_q == DivLast) begin
          if (dsel_q) cq_q <= dv_qsat;
          else aq_q <= dv_qsat;
        end
      end
      DsRootSq: begin
        rad_q  <= 62'(58'(dm_w) * 58'(dm_w)) + 62'({cq_q, 16'b0});
        root_q <= '0;
        srem_q <= '0;
      end
      DsRootRun: begin
        rad_q  <= rad_q << 2;
        srem_q <= sq_rem_d;
        root_q <= sq_root_d;
      end
      DsExpo: begin
        expo_q    <= y32;
        unit_q    <= y_unit;
        invalid_q <= y_bad;
      end
      DsLogInit: begin
        lm_q  <= norm_mant(lx, lp_w);
        lp_q  <= lp_w;
        lfr_q <= '0;
      end
      DsLogRun: begin
        lm_q  <= lst.m;
        lfr_q <= {lfr_q[22:0], lst.b};
      end
      DsLogDone: begin
        case (lsel_q)
          2'd0: lk_q <= lval;
          2'd1: l1_q <= lval;
          default: begin
            ratio_q <= l1_q - lval - lk_q;
            coef_q  <= lk_q - l1_q;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign ready_o           = (state_q == DsReady);
  assign derived_o.expo    = expo_q;
  assign derived_o.ratio   = ratio_q;
  assign derived_o.coef    = coef_q;
  assign derived_o.invalid = invalid_q;
  assign derived_o.unit    = unit_q;
  assign derived_o.tab     = tab_q;

endmodule

### rtl/pao_log_pipe.sv
module pao_log_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  pao_pkg::mant_t                mant_i,
  input  pao_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [pao_pkg::LogFrac-1:0]   frac_o,
  output pao_pkg::side_t                side_o
);
  import pao_pkg::*;

  logic              vld_q  [1:LogSteps];
  mant_t             m_q    [1:LogSteps];
  logic [LogFrac-1:0] fr_q  [1:LogSteps];
  side_t             sd_q   [1:LogSteps];

  for (genvar k = 1; k <= LogSteps; k++) begin : g_stage
    logic               vld_prev;
    mant_t              m_prev;
    logic [LogFrac-1:0] fr_prev;
    side_t              sd_prev;
    log_step_t          st;

    if (k == 1) begin : g_first
      assign vld_prev = valid_i;
      assign m_prev   = mant_i;
      assign fr_prev  = '0;
      assign sd_prev  = side_i;
    end else begin : g_next
      assign vld_prev = vld_q[k-1];
      assign m_prev   = m_q[k-1];
      assign fr_prev  = fr_q[k-1];
      assign sd_prev  = sd_q[k-1];
    end

    assign st = log_step(m_prev);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      m_q[k]  <= st.m;
      fr_q[k] <= {fr_prev[LogFrac-2:0], st.b};
      sd_q[k] <= sd_prev;
    end
  end

  assign valid_o = vld_q[LogSteps];
  assign frac_o  = fr_q[LogSteps];
  assign side_o  = sd_q[LogSteps];

endmodule

### rtl/pao_exp_pipe.sv
module pao_exp_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [pao_pkg::LogFrac-1:0] frac_i,
  input  pao_pkg::side_t              side_i,
  input  pao_pkg::exp_tab_t           tab_i,
  output logic                        valid_o,
  output pao_pkg::mant_t              mant_o,
  output pao_pkg::side_t              side_o
);
  import pao_pkg::*;

  logic               vld_q [1:LogSteps];
  mant_t              m_q   [1:LogSteps];
  logic [LogFrac-1:0] f_q   [1:LogSteps];
  side_t              sd_q  [1:LogSteps];

  // Stage k multiplies by 2^(2^-k) when fraction bit k (from the top) is set.
  for (genvar k = 1; k <= LogSteps; k++) begin : g_stage
    logic                   vld_prev;
    mant_t                  m_prev;
    logic [LogFrac-1:0]     f_prev;
    side_t                  sd_prev;
    logic [2*MantWidth-1:0] prod;

    if (k == 1) begin : g_first
      assign vld_prev = valid_i;
      assign m_prev   = mant_t'(1) << (MantWidth - 1);
      assign f_prev   = frac_i;
      assign sd_prev  = side_i;
    end else begin : g_next
      assign vld_prev = vld_q[k-1];
      assign m_prev   = m_q[k-1];
      assign f_prev   = f_q[k-1];
      assign sd_prev  = sd_q[k-1];
    end

    assign prod = (2*MantWidth)'(m_prev) * (2*MantWidth)'(tab_i[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      m_q[k]  <= f_prev[LogFrac-k] ? prod[2*MantWidth-2:MantWidth-1] : m_prev;
      f_q[k]  <= f_prev;
      sd_q[k] <= sd_prev;
    end
  end

  assign valid_o = vld_q[LogSteps];
  assign mant_o  = m_q[LogSteps];
  assign side_o  = sd_q[LogSteps];

endmodule

### rtl/perpetual_american_option_price.sv
// Perpetual American option pricer, one underlying price per beat.
// Configuration: APB-style slave, registers at byte addresses 0 (rate),
// 4 (volatility), 8 (strike), 12 (carry), 16 (put select). pready is always
// high; a write takes a setup and an access cycle. Any register write starts
// a recomputation of the exponent, log coefficients and the exp2 table.
// Recomputation runs a shared square-root, divider and log2 sequencer;
// busy is high during it. The same pass runs after reset.
// Input: a beat is taken when start is high and busy is low. One beat can
// be taken every cycle while busy is low; the per-item datapath is a
// 54-stage pipeline (a front stage, 24 log2 squaring stages, four
// multiply/align stages, 24 exp2 multiply stages, an output stage), so
// done_o pulses for one cycle with option_price_o and price_status_o.
// Results come out in order and cannot be held off by the receiver.
// Reset clears the pipeline valid bits and restores the register defaults.
module perpetual_american_option_price
  import pao_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pao_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [pao_pkg::PriceWidth-1:0] underlying_price_i,
  output logic                          done_o,
  output logic [pao_pkg::OutWidth-1:0]  option_price_o,
  output logic [1:0]                    price_status_o
);

  localparam logic signed [51:0] EBias = 52'(PriceFrac) <<< LogFrac;
  localparam logic signed [51:0] ESat  = 52'(32) <<< LogFrac;

  // Configuration registers.
  logic [15:0] rate_q, vol_q;
  logic [23:0] strike_q;
  logic [16:0] carry_q;
  logic        put_q;
  logic        cfg_we, cfg_restart;
  cfg_reg_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[4:2]);

  always_comb begin
    case (cfg_idx)
      RegRate, RegVol, RegStrike, RegCarry, RegPut: cfg_restart = cfg_we;
      default: cfg_restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= 16'd3277;
      vol_q    <= 16'd13107;
      strike_q <= 24'd28160;
      carry_q  <= 17'd3277;
      put_q    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegRate:   rate_q   <= pwdata[15:0];
        RegVol:    vol_q    <= pwdata[15:0];
        RegStrike: strike_q <= pwdata[23:0];
        RegCarry:  carry_q  <= pwdata[16:0];
        RegPut:    put_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegRate:   prdata = 32'(rate_q);
      RegVol:    prdata = 32'(vol_q);
      RegStrike: prdata = 32'(strike_q);
      RegCarry:  prdata = 32'(carry_q);
      RegPut:    prdata = 32'(put_q);
      default:   prdata = '0;
    endcase
  end

  derived_t drv;
  logic     drv_ready;

  pao_derive u_derive (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_restart),
    .rate_i    (rate_q),
    .vol_i     (vol_q),
    .strike_i  (strike_q),
    .carry_i   (carry_q),
    .put_i     (put_q),
    .ready_o   (drv_ready),
    .derived_o (drv)
  );

  assign busy = !drv_ready;

  // Front stage: normalize S and settle the special cases.
  logic       acc;
  logic [4:0] s_msb;
  mant_t      f_mant;
  side_t      f_side;
  logic       fv_q;
  mant_t      fm_q;
  side_t      fs_q;

  assign acc = start && !busy;

  always_comb begin
    s_msb  = msb_pos(32'(underlying_price_i));
    f_mant = norm_mant(32'(underlying_price_i), s_msb);
    f_side = '0;
    f_side.lexp = $signed({3'b000, s_msb}) - 8'(PriceFrac);
    if (drv.invalid) begin
      f_side.force_res = 1'b1;
      f_side.fstatus   = StInvalid;
    end else if (drv.unit) begin
      f_side.force_res = 1'b1;
      f_side.fprice    = 32'(underlying_price_i);
      f_side.fstatus   = StPass;
    end else if (underlying_price_i == '0) begin
      f_side.force_res = 1'b1;
      if (drv.expo[31]) begin
        f_side.fprice  = '1;
        f_side.fstatus = StSat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fv_q <= 1'b0;
    else fv_q <= acc;
  end

  always_ff @(posedge clk_i) begin
    fm_q <= f_mant;
    fs_q <= f_side;
  end

  logic               l_valid;
  logic [LogFrac-1:0] l_frac;
  side_t              l_side;

  pao_log_pipe u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv_q),
    .mant_i  (fm_q),
    .side_i  (fs_q),
    .valid_o (l_valid),
    .frac_o  (l_frac),
    .side_o  (l_side)
  );

  // Align stages: t = ratio + log2 S, p = y * t, e = coef + p/2^16 + bias.
  logic signed [31:0] logs;
  logic signed [33:0] t_q;
  logic signed [65:0] pr_d, pr_q;
  logic signed [51:0] e_d, e_q, ipf;
  logic               tv_q, pv_q, ev_q, iv_q;
  side_t              ts_q, ps_q, es_q, is_q, i_side;
  logic [LogFrac-1:0] if_q;

  assign logs = {l_side.lexp, l_frac};
  assign pr_d = drv.expo * t_q;
  assign e_d  = 52'(drv.coef) + 52'(pr_q >>> 16) + EBias;
  assign ipf  = e_q >>> LogFrac;

  always_comb begin
    i_side       = es_q;
    i_side.sat   = (e_q >= ESat);
    i_side.under = (ipf < -52'sd32);
    i_side.ip    = 7'(ipf);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
      pv_q <= 1'b0;
      ev_q <= 1'b0;
      iv_q <= 1'b0;
    end else begin
      tv_q <= l_valid;
      pv_q <= tv_q;
      ev_q <= pv_q;
      iv_q <= ev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q  <= 34'(drv.ratio) + 34'(logs);
    ts_q <= l_side;
    pr_q <= pr_d;
    ps_q <= ts_q;
    e_q  <= e_d;
    es_q <= ps_q;
    if_q <= e_q[LogFrac-1:0];
    is_q <= i_side;
  end

  logic  x_valid;
  mant_t x_mant;
  side_t x_side;

  pao_exp_pipe u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (iv_q),
    .frac_i  (if_q),
    .side_i  (is_q),
    .tab_i   (drv.tab),
    .valid_o (x_valid),
    .mant_o  (x_mant),
    .side_o  (x_side)
  );

  // Output stage: scale by 2^ip with rounding, then saturate, flush to zero or apply a forced result.
  logic [5:0]          sh;
  logic [62:0]         rnd;
  logic [63:0]         res;
  logic [OutWidth-1:0] price_d;
  status_e             status_d;
  logic                done_q;
  logic [OutWidth-1:0] price_q;
  status_e             status_q;

  always_comb begin
    sh  = 6'(7'sd30 - x_side.ip);
    rnd = (63'(x_mant) + (63'd1 << (sh - 6'd1))) >> sh;
    if (x_side.ip >= 7'sd30) res = 64'(x_mant) << x_side.ip[0];
    else res = 64'(rnd);
    if (x_side.force_res) begin
      price_d  = x_side.fprice;
      status_d = x_side.fstatus;
    end else if (x_side.sat || (res > 64'(32'hFFFF_FFFF))) begin
      price_d  = '1;
      status_d = StSat;
    end else if (x_side.under) begin
      price_d  = '0;
      status_d = StNormal;
    end else begin
      price_d  = res[OutWidth-1:0];
      status_d = StNormal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= x_valid;
  end

  always_ff @(posedge clk_i) begin
    price_q  <= price_d;
    status_q <= status_d;
  end

  assign done_o         = done_q;
  assign option_price_o = price_q;
  assign price_status_o = status_q;

`ifndef SYNTHESIS
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_restart |=> busy)
    else $error("register write did not start a recomputation");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (price_status_o == StInvalid) |-> (option_price_o == '0))
    else $error("invalid result carries a nonzero price");
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (price_status_o == StSat) |-> (option_price_o == '1))
    else $error("saturated result is not all ones");
`endif

endmodule
